// ===== sv/ewtab_pkg.sv =====
package ewtab_pkg;

   localparam int PRODUCT_COUNT_DEF = 256;

   // item field widths
   localparam int ACTION_W = 2;
   localparam int INDEX_W  = 8;
   localparam int SALE_W   = 16;
   localparam int Q_W      = 24;
   localparam int ALPHA_W  = 16;

   // arithmetic widths
   localparam int MAG_W   = SALE_W - 1;
   localparam int FRAC_W  = 8;
   localparam int SEED_SH = 6;
   localparam int OM_W    = ALPHA_W + 1;
   localparam int MUL_W   = 24;
   localparam int PROD_W  = 2 * MUL_W;
   localparam int ACC_W   = 64;
   localparam int VP_W    = 49;
   localparam int RAD_W   = 50;
   localparam int ROOT_W  = 25;
   localparam int NM_W    = 26;
   localparam int RND_SH  = 16;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_IDX_ALPHA = 1'b0;
   localparam logic CSR_IDX_FLOOR = 1'b1;

   localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd22938;
   localparam logic [Q_W-1:0]     FLOOR_RESET = 24'd64;

   typedef enum logic [ACTION_W-1:0] {
      ACT_UPDATE = 2'd0,
      ACT_READ   = 2'd1,
      ACT_SET    = 2'd2
   } action_type;

   typedef struct packed {
      logic [ALPHA_W-1:0] alpha;
      logic [Q_W-1:0]     std_floor;
   } cfg_type;

   typedef struct packed {
      logic           valid;
      logic [Q_W-1:0] mean;
      logic [Q_W-1:0] std_dev;
   } entry_type;

   typedef struct packed {
      logic               start;
      logic [ALPHA_W-1:0] alpha;
      logic [Q_W-1:0]     mean;
      logic [Q_W-1:0]     std_dev;
      logic [MAG_W-1:0]   sale;
   } upd_req_type;

   typedef struct packed {
      logic           done;
      logic [Q_W-1:0] mean;
      logic [Q_W-1:0] std_dev;
   } upd_rsp_type;

endpackage

// ===== sv/ewtab_req_if.sv =====
interface ewtab_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [ewtab_pkg::ACTION_W-1:0]        action;
   logic [ewtab_pkg::INDEX_W-1:0]         product_index;
   logic signed [ewtab_pkg::SALE_W-1:0]   sold_qty;
   logic [ewtab_pkg::Q_W-1:0]             set_mean;
   logic [ewtab_pkg::Q_W-1:0]             set_std_dev;

   modport source (
      output valid, action, product_index, sold_qty, set_mean, set_std_dev,
      input  ready
   );

   modport sink (
      input  valid, action, product_index, sold_qty, set_mean, set_std_dev,
      output ready
   );
endinterface

// ===== sv/ewtab_rsp_if.sv =====
interface ewtab_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [ewtab_pkg::Q_W-1:0] mean_out;
   logic [ewtab_pkg::Q_W-1:0] std_dev_out;
   logic                      was_known;

   modport source (
      output valid, mean_out, std_dev_out, was_known,
      input  ready
   );

   modport sink (
      input  valid, mean_out, std_dev_out, was_known,
      output ready
   );
endinterface

// ===== sv/ewtab_csr.sv =====
module ewtab_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [ewtab_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [ewtab_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [ewtab_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                                pready,
   output ewtab_pkg::cfg_type                  cfg
);

   logic [ewtab_pkg::ALPHA_W-1:0] alpha_ff;
   logic [ewtab_pkg::ALPHA_W-1:0] alpha_in;
   logic [ewtab_pkg::Q_W-1:0]     floor_ff;
   logic [ewtab_pkg::Q_W-1:0]     floor_in;
   logic                          wr_en;
   logic                          reg_sel;

   // register index is the word address, byte offset ignored
   assign reg_sel = paddr[2];
   assign wr_en   = psel & penable & pwrite;
   assign pready  = 1'b1;

   always_comb begin
      alpha_in = alpha_ff;
      floor_in = floor_ff;
      if (wr_en) begin
         case (reg_sel)
            ewtab_pkg::CSR_IDX_ALPHA: alpha_in = pwdata[ewtab_pkg::ALPHA_W-1:0];
            ewtab_pkg::CSR_IDX_FLOOR: floor_in = pwdata[ewtab_pkg::Q_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         ewtab_pkg::CSR_IDX_ALPHA: prdata = ewtab_pkg::CSR_DATA_W'(alpha_ff);
         ewtab_pkg::CSR_IDX_FLOOR: prdata = ewtab_pkg::CSR_DATA_W'(floor_ff);
         default:                  prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= ewtab_pkg::ALPHA_RESET;
         floor_ff <= ewtab_pkg::FLOOR_RESET;
      end else begin
         alpha_ff <= alpha_in;
         floor_ff <= floor_in;
      end
   end

   assign cfg.alpha     = alpha_ff;
   assign cfg.std_floor = floor_ff;

endmodule

// ===== sv/ewtab_isqrt.sv =====
module ewtab_isqrt (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [ewtab_pkg::RAD_W-1:0]      radicand,
   output logic                             done,
   output logic [ewtab_pkg::ROOT_W-1:0]     root
);

   localparam int REM_W = ewtab_pkg::ROOT_W + 2;
   localparam int CNT_W = $clog2(ewtab_pkg::ROOT_W);
   localparam logic [CNT_W-1:0] LAST_ITER = CNT_W'(ewtab_pkg::ROOT_W - 1);

   logic                           busy_ff;
   logic                           busy_in;
   logic                           done_ff;
   logic                           done_in;
   logic [CNT_W-1:0]               cnt_ff;
   logic [CNT_W-1:0]               cnt_in;
   logic [ewtab_pkg::RAD_W-1:0]    x_ff;
   logic [ewtab_pkg::RAD_W-1:0]    x_in;
   logic [REM_W-1:0]               rem_ff;
   logic [REM_W-1:0]               rem_in;
   logic [ewtab_pkg::ROOT_W-1:0]   root_ff;
   logic [ewtab_pkg::ROOT_W-1:0]   root_in;
   logic [REM_W-1:0]               rem_shift;
   logic [REM_W-1:0]               trial;

   // one root bit per cycle, two radicand bits brought down each time
   assign rem_shift = {rem_ff[REM_W-3:0], x_ff[ewtab_pkg::RAD_W-1 -: 2]};
   assign trial     = {root_ff, 2'b01};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      x_in    = x_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         x_in    = radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         x_in = {x_ff[ewtab_pkg::RAD_W-3:0], 2'b00};
         if (rem_shift >= trial) begin
            rem_in  = rem_shift - trial;
            root_in = {root_ff[ewtab_pkg::ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_shift;
            root_in = {root_ff[ewtab_pkg::ROOT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_ITER) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      x_ff    <= x_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// ===== sv/ewtab_update_unit.sv =====
module ewtab_update_unit (
   input  logic                    clock,
   input  logic                    reset,
   input  ewtab_pkg::upd_req_type  upd_req,
   output ewtab_pkg::upd_rsp_type  upd_rsp
);

   localparam int MUL_W  = ewtab_pkg::MUL_W;
   localparam int PROD_W = ewtab_pkg::PROD_W;
   localparam int ACC_W  = ewtab_pkg::ACC_W;
   localparam int Q_W    = ewtab_pkg::Q_W;
   localparam int RND_SH = ewtab_pkg::RND_SH;
   localparam int LO_W   = RND_SH + 1;
   localparam int STEP_W = 4;
   localparam logic [ACC_W-1:0] HALF = ACC_W'(1) << (RND_SH - 1);

   // multiplier issue / accumulate schedule
   localparam logic [STEP_W-1:0] STEP_DD     = 4'd0;
   localparam logic [STEP_W-1:0] STEP_SS     = 4'd1;
   localparam logic [STEP_W-1:0] STEP_AD_LO  = 4'd2;
   localparam logic [STEP_W-1:0] STEP_AD_HI  = 4'd3;
   localparam logic [STEP_W-1:0] STEP_AS     = 4'd4;
   localparam logic [STEP_W-1:0] STEP_OM     = 4'd5;
   localparam logic [STEP_W-1:0] STEP_VP_LO  = 4'd6;
   localparam logic [STEP_W-1:0] STEP_VP_MID = 4'd7;
   localparam logic [STEP_W-1:0] STEP_VP_HI  = 4'd8;
   localparam logic [STEP_W-1:0] STEP_SUM    = 4'd9;

   typedef enum logic [2:0] {
      U_IDLE = 3'b001,
      U_MUL  = 3'b010,
      U_ROOT = 3'b100
   } unit_state_type;

   unit_state_type                    state_ff;
   unit_state_type                    state_in;
   logic [STEP_W-1:0]                 step_ff;
   logic [STEP_W-1:0]                 step_in;
   logic [ewtab_pkg::ALPHA_W-1:0]     alpha_ff;
   logic [ewtab_pkg::ALPHA_W-1:0]     alpha_in;
   logic [ewtab_pkg::OM_W-1:0]        om_ff;
   logic [ewtab_pkg::OM_W-1:0]        om_in;
   logic [Q_W-1:0]                    sale_ff;
   logic [Q_W-1:0]                    sale_in;
   logic [Q_W-1:0]                    mean_ff;
   logic [Q_W-1:0]                    mean_in;
   logic [Q_W-1:0]                    sd_ff;
   logic [Q_W-1:0]                    sd_in;
   logic [Q_W-1:0]                    d_ff;
   logic [Q_W-1:0]                    d_in;
   logic [PROD_W-1:0]                 prod_ff;
   logic [PROD_W-1:0]                 prod_in;
   logic [PROD_W-1:0]                 d2_ff;
   logic [PROD_W-1:0]                 d2_in;
   logic [PROD_W-1:0]                 sq_ff;
   logic [PROD_W-1:0]                 sq_in;
   logic [PROD_W-1:0]                 t_ff;
   logic [PROD_W-1:0]                 t_in;
   logic [ewtab_pkg::VP_W-1:0]        vp_ff;
   logic [ewtab_pkg::VP_W-1:0]        vp_in;
   logic [ACC_W-1:0]                  acc_ff;
   logic [ACC_W-1:0]                  acc_in;
   logic [ewtab_pkg::NM_W-1:0]        nm_ff;
   logic [ewtab_pkg::NM_W-1:0]        nm_in;
   logic [LO_W-1:0]                   lo_ff;
   logic [LO_W-1:0]                   lo_in;
   logic [MUL_W-1:0]                  mul_a;
   logic [MUL_W-1:0]                  mul_b;
   logic [Q_W-1:0]                    start_sale;
   logic                              root_start;
   logic [ewtab_pkg::RAD_W-1:0]       radicand;
   logic                              root_done;
   logic [ewtab_pkg::ROOT_W-1:0]      root;

   assign start_sale = Q_W'({upd_req.sale, {ewtab_pkg::FRAC_W{1'b0}}});

   // var = om*(vp>>16) + round(om*(vp & 0xffff) >> 16), upper part added last
   assign radicand = ewtab_pkg::RAD_W'(acc_ff)
                   + (ewtab_pkg::RAD_W'(prod_ff) << MUL_W);

   assign prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);

   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      alpha_in   = alpha_ff;
      om_in      = om_ff;
      sale_in    = sale_ff;
      mean_in    = mean_ff;
      sd_in      = sd_ff;
      d_in       = d_ff;
      d2_in      = d2_ff;
      sq_in      = sq_ff;
      t_in       = t_ff;
      vp_in      = vp_ff;
      acc_in     = acc_ff;
      nm_in      = nm_ff;
      lo_in      = lo_ff;
      mul_a      = '0;
      mul_b      = '0;
      root_start = 1'b0;
      case (state_ff)
         U_IDLE: begin
            if (upd_req.start) begin
               alpha_in = upd_req.alpha;
               om_in    = (ewtab_pkg::OM_W'(1) << ewtab_pkg::ALPHA_W)
                        - ewtab_pkg::OM_W'(upd_req.alpha);
               sale_in  = start_sale;
               mean_in  = upd_req.mean;
               sd_in    = upd_req.std_dev;
               d_in     = (start_sale >= upd_req.mean) ? start_sale - upd_req.mean
                                                       : upd_req.mean - start_sale;
               step_in  = STEP_DD;
               state_in = U_MUL;
            end
         end
         U_MUL: begin
            step_in = step_ff + 1'b1;
            case (step_ff)
               STEP_DD: begin
                  mul_a = d_ff;
                  mul_b = d_ff;
               end
               STEP_SS: begin
                  d2_in = prod_ff;
                  mul_a = sd_ff;
                  mul_b = sd_ff;
               end
               STEP_AD_LO: begin
                  sq_in = prod_ff;
                  mul_a = MUL_W'(alpha_ff);
                  mul_b = d2_ff[MUL_W-1:0];
               end
               STEP_AD_HI: begin
                  acc_in = ACC_W'(prod_ff);
                  mul_a  = MUL_W'(alpha_ff);
                  mul_b  = d2_ff[PROD_W-1:MUL_W];
               end
               STEP_AS: begin
                  // t = round(a * d^2 >> 16)
                  t_in  = PROD_W'((acc_ff + (ACC_W'(prod_ff) << MUL_W) + HALF) >> RND_SH);
                  mul_a = MUL_W'(alpha_ff);
                  mul_b = sale_ff;
               end
               STEP_OM: begin
                  vp_in  = ewtab_pkg::VP_W'(sq_ff) + ewtab_pkg::VP_W'(t_ff);
                  acc_in = ACC_W'(prod_ff);
                  mul_a  = MUL_W'(om_ff);
                  mul_b  = mean_ff;
               end
               STEP_VP_LO: begin
                  nm_in = ewtab_pkg::NM_W'((acc_ff + ACC_W'(prod_ff) + HALF) >> RND_SH);
                  mul_a = MUL_W'(om_ff);
                  mul_b = MUL_W'(vp_ff[RND_SH-1:0]);
               end
               STEP_VP_MID: begin
                  lo_in = LO_W'((ACC_W'(prod_ff) + HALF) >> RND_SH);
                  mul_a = MUL_W'(om_ff);
                  mul_b = vp_ff[RND_SH+MUL_W-1:RND_SH];
               end
               STEP_VP_HI: begin
                  acc_in = ACC_W'(prod_ff) + ACC_W'(lo_ff);
                  mul_a  = MUL_W'(om_ff);
                  mul_b  = MUL_W'(vp_ff[ewtab_pkg::VP_W-1:RND_SH+MUL_W]);
               end
               STEP_SUM: begin
                  root_start = 1'b1;
                  state_in   = U_ROOT;
               end
               default: state_in = U_IDLE;
            endcase
         end
         U_ROOT: begin
            if (root_done) begin
               state_in = U_IDLE;
            end
         end
         default: state_in = U_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff  <= step_in;
      alpha_ff <= alpha_in;
      om_ff    <= om_in;
      sale_ff  <= sale_in;
      mean_ff  <= mean_in;
      sd_ff    <= sd_in;
      d_ff     <= d_in;
      prod_ff  <= prod_in;
      d2_ff    <= d2_in;
      sq_ff    <= sq_in;
      t_ff     <= t_in;
      vp_ff    <= vp_in;
      acc_ff   <= acc_in;
      nm_ff    <= nm_in;
      lo_ff    <= lo_in;
   end

   ewtab_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .radicand (radicand),
      .done     (root_done),
      .root     (root)
   );

   // both results saturate at the top of the Q16.8 range
   assign upd_rsp.done    = (state_ff == U_ROOT) & root_done;
   assign upd_rsp.mean    = (|nm_ff[ewtab_pkg::NM_W-1:Q_W]) ? '1 : nm_ff[Q_W-1:0];
   assign upd_rsp.std_dev = (|root[ewtab_pkg::ROOT_W-1:Q_W]) ? '1 : root[Q_W-1:0];

endmodule

// ===== sv/per_key_ewma_mean_stddev_table_core.sv =====
// Per-product table of exponentially weighted mean and standard deviation (Q16.8).
// Items arrive on req_chan (valid/ready): action, product_index, sold_qty,
// set_mean, set_std_dev. Each item gives exactly one result on rsp_chan (valid/ready):
// mean_out, std_dev_out and was_known. Smoothing weight and deviation floor are
// written over the APB port (alpha at byte 0, floor at byte 4).
// One item is worked on at a time; the table lives in a single memory with a
// registered read, so read, set, first sample and out-of-range items pass through
// ST_LOOKUP and ST_DONE into the output register.
// An update of a known entry runs a 10-step schedule on the shared 24x24
// multiplier, then a 25-step bit-serial square root, then the write back.
// The result sits in an output register; the next item is taken while it waits,
// and a stalled receiver only holds the block once a second result is ready.
// After reset the block sweeps the table clearing every valid mark, one entry per
// cycle, with req_chan.ready low until the sweep ends; the registers return to
// alpha 22938 and floor 64 and can be written during the sweep.
module per_key_ewma_mean_stddev_table_core #(
   parameter int PRODUCT_COUNT = ewtab_pkg::PRODUCT_COUNT_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   ewtab_req_if.sink                           req_chan,
   ewtab_rsp_if.source                         rsp_chan,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [ewtab_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [ewtab_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [ewtab_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                                pready
);

   localparam int ADDR_W  = $clog2(PRODUCT_COUNT);
   localparam int RANGE_W = 17;
   localparam int Q_W     = ewtab_pkg::Q_W;
   localparam int MAG_W   = ewtab_pkg::MAG_W;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(PRODUCT_COUNT - 1);

   typedef enum logic [4:0] {
      ST_CLEAR  = 5'b00001,
      ST_IDLE   = 5'b00010,
      ST_LOOKUP = 5'b00100,
      ST_CALC   = 5'b01000,
      ST_DONE   = 5'b10000
   } core_state_type;

   ewtab_pkg::cfg_type                 cfg;
   ewtab_pkg::upd_req_type             upd_req;
   ewtab_pkg::upd_rsp_type             upd_rsp;
   ewtab_pkg::entry_type               entry_mem [PRODUCT_COUNT];
   ewtab_pkg::entry_type               mem_rd_data_ff;
   ewtab_pkg::entry_type               mem_wr_data;
   logic                               mem_rd_en;
   logic                               mem_wr_en;
   logic [ADDR_W-1:0]                  mem_wr_addr;
   logic [ADDR_W-1:0]                  req_addr;

   core_state_type                     state_ff;
   core_state_type                     state_in;
   logic [ADDR_W-1:0]                  clr_cnt_ff;
   logic [ADDR_W-1:0]                  clr_cnt_in;
   logic [ewtab_pkg::ACTION_W-1:0]     act_ff;
   logic [ewtab_pkg::ACTION_W-1:0]     act_in;
   logic                               in_range_ff;
   logic                               in_range_in;
   logic [ADDR_W-1:0]                  addr_ff;
   logic [ADDR_W-1:0]                  addr_in;
   logic [MAG_W-1:0]                   sale_ff;
   logic [MAG_W-1:0]                   sale_in;
   logic [Q_W-1:0]                     set_mean_ff;
   logic [Q_W-1:0]                     set_mean_in;
   logic [Q_W-1:0]                     set_sd_ff;
   logic [Q_W-1:0]                     set_sd_in;
   logic [Q_W-1:0]                     res_mean_ff;
   logic [Q_W-1:0]                     res_mean_in;
   logic [Q_W-1:0]                     res_sd_ff;
   logic [Q_W-1:0]                     res_sd_in;
   logic                               res_known_ff;
   logic                               res_known_in;
   logic                               rsp_valid_ff;
   logic                               rsp_valid_in;
   logic [Q_W-1:0]                     rsp_mean_ff;
   logic [Q_W-1:0]                     rsp_mean_in;
   logic [Q_W-1:0]                     rsp_sd_ff;
   logic [Q_W-1:0]                     rsp_sd_in;
   logic                               rsp_known_ff;
   logic                               rsp_known_in;

   logic                               req_accept;
   logic                               rsp_accept;
   logic                               out_free;
   logic                               load_out;
   logic                               entry_write;
   logic                               lookup_known;
   logic [MAG_W-1:0]                   req_sale_mag;

   function automatic logic [Q_W-1:0] raise_to_floor(input logic [Q_W-1:0] value,
                                                     input logic [Q_W-1:0] lower);
      return (value < lower) ? lower : value;
   endfunction

   ewtab_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   ewtab_update_unit u_update (
      .clock   (clock),
      .reset   (reset),
      .upd_req (upd_req),
      .upd_rsp (upd_rsp)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_accept     = req_chan.valid & req_chan.ready;
   assign rsp_accept     = rsp_valid_ff & rsp_chan.ready;
   assign out_free       = ~rsp_valid_ff | rsp_chan.ready;
   assign req_addr       = ADDR_W'(req_chan.product_index);
   // negative sales count as zero
   assign req_sale_mag   = req_chan.sold_qty[ewtab_pkg::SALE_W-1] ? '0
                         : req_chan.sold_qty[MAG_W-1:0];
   assign lookup_known   = in_range_ff & mem_rd_data_ff.valid;

   always_comb begin
      state_in        = state_ff;
      clr_cnt_in      = clr_cnt_ff;
      act_in          = act_ff;
      in_range_in     = in_range_ff;
      addr_in         = addr_ff;
      sale_in         = sale_ff;
      set_mean_in     = set_mean_ff;
      set_sd_in       = set_sd_ff;
      res_mean_in     = res_mean_ff;
      res_sd_in       = res_sd_ff;
      res_known_in    = res_known_ff;
      mem_rd_en       = 1'b0;
      mem_wr_en       = 1'b0;
      mem_wr_addr     = addr_ff;
      mem_wr_data     = '0;
      entry_write     = 1'b0;
      load_out        = 1'b0;
      upd_req.start   = 1'b0;
      upd_req.alpha   = cfg.alpha;
      upd_req.mean    = mem_rd_data_ff.mean;
      upd_req.std_dev = mem_rd_data_ff.std_dev;
      upd_req.sale    = sale_ff;
      case (state_ff)
         ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_cnt_ff;
            clr_cnt_in  = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               act_in      = req_chan.action;
               in_range_in = RANGE_W'(req_chan.product_index) < RANGE_W'(PRODUCT_COUNT);
               addr_in     = req_addr;
               sale_in     = req_sale_mag;
               set_mean_in = req_chan.set_mean;
               set_sd_in   = req_chan.set_std_dev;
               mem_rd_en   = 1'b1;
               state_in    = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            res_known_in = lookup_known;
            res_mean_in  = lookup_known ? mem_rd_data_ff.mean : '0;
            res_sd_in    = lookup_known ? mem_rd_data_ff.std_dev : cfg.std_floor;
            state_in     = ST_DONE;
            if (in_range_ff) begin
               case (act_ff)
                  ewtab_pkg::ACT_UPDATE: begin
                     if (lookup_known) begin
                        upd_req.start = 1'b1;
                        state_in      = ST_CALC;
                     end else begin
                        // first sample seeds mean with the sale, sd with a quarter of it
                        res_mean_in = Q_W'({sale_ff, {ewtab_pkg::FRAC_W{1'b0}}});
                        res_sd_in   = raise_to_floor(
                                         Q_W'({sale_ff, {ewtab_pkg::SEED_SH{1'b0}}}),
                                         cfg.std_floor);
                        entry_write = 1'b1;
                     end
                  end
                  ewtab_pkg::ACT_SET: begin
                     res_mean_in = set_mean_ff;
                     res_sd_in   = raise_to_floor(set_sd_ff, cfg.std_floor);
                     entry_write = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
         ST_CALC: begin
            if (upd_rsp.done) begin
               res_mean_in = upd_rsp.mean;
               res_sd_in   = raise_to_floor(upd_rsp.std_dev, cfg.std_floor);
               entry_write = 1'b1;
               state_in    = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (entry_write) begin
         mem_wr_en           = 1'b1;
         mem_wr_data.valid   = 1'b1;
         mem_wr_data.mean    = res_mean_in;
         mem_wr_data.std_dev = res_sd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         entry_mem[mem_wr_addr] <= mem_wr_data;
      end
      if (mem_rd_en) begin
         mem_rd_data_ff <= entry_mem[req_addr];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_mean_in  = rsp_mean_ff;
      rsp_sd_in    = rsp_sd_ff;
      rsp_known_in = rsp_known_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
         rsp_mean_in  = res_mean_ff;
         rsp_sd_in    = res_sd_ff;
         rsp_known_in = res_known_ff;
      end else if (rsp_accept) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff       <= act_in;
      in_range_ff  <= in_range_in;
      addr_ff      <= addr_in;
      sale_ff      <= sale_in;
      set_mean_ff  <= set_mean_in;
      set_sd_ff    <= set_sd_in;
      res_mean_ff  <= res_mean_in;
      res_sd_ff    <= res_sd_in;
      res_known_ff <= res_known_in;
      rsp_mean_ff  <= rsp_mean_in;
      rsp_sd_ff    <= rsp_sd_in;
      rsp_known_ff <= rsp_known_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.mean_out    = rsp_mean_ff;
   assign rsp_chan.std_dev_out = rsp_sd_ff;
   assign rsp_chan.was_known   = rsp_known_ff;

endmodule

// ===== tb/sv/per_key_ewma_mean_stddev_table_core_test.sv =====
`timescale 1ns / 100ps

module per_key_ewma_mean_stddev_table_core_test;
   import ewtab_pkg::*;

   localparam int TABLE_DEPTH = PRODUCT_COUNT_DEF;
   localparam int QUIET_LIMIT = 4000;
   localparam int PHASE_ITEMS = 140;
   localparam int HOLD_AFTER  = 250;
   localparam int HOLD_CYCLES = 300;
   localparam logic [ACTION_W-1:0]   ACT_SPARE  = 2'd3;
   localparam logic [CSR_ADDR_W-1:0] ALPHA_ADDR = {CSR_IDX_ALPHA, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] FLOOR_ADDR = {CSR_IDX_FLOOR, 2'b00};
   localparam logic [63:0] Q_MAX = 64'hFF_FFFF;

   typedef struct packed {
      logic [ACTION_W-1:0]      action;
      logic [INDEX_W-1:0]       index;
      logic signed [SALE_W-1:0] sale;
      logic [Q_W-1:0]           set_mean;
      logic [Q_W-1:0]           set_sd;
   } demand_item_type;

   typedef struct packed {
      logic [Q_W-1:0] mean;
      logic [Q_W-1:0] sd;
      logic           known;
   } demand_result_type;

   typedef struct packed {
      demand_item_type   item;
      logic              typed;
      demand_result_type want;
   } directed_row_type;

   logic clock;
   logic reset;
   logic psel, penable, pwrite, pready;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata, prdata;

   ewtab_req_if req_chan ();
   ewtab_rsp_if rsp_chan ();

   per_key_ewma_mean_stddev_table_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   // shadow of the table and tuning registers
   logic [ALPHA_W-1:0] alpha_w = ALPHA_RESET;
   logic [Q_W-1:0]     floor_w = FLOOR_RESET;
   logic               est_valid [TABLE_DEPTH] = '{default: 1'b0};
   logic [Q_W-1:0]     est_mean  [TABLE_DEPTH];
   logic [Q_W-1:0]     est_sd    [TABLE_DEPTH];

   demand_result_type expected_demand [$];
   demand_result_type arrived;
   int fault_count  = 0;
   int results_seen = 0;
   int burst_left   = 0;

   directed_row_type dir_tab [25] = '{
      '{'{ACT_READ,   8'd0,   16'sd0,     24'd0, 24'd0}, 1'b1, '{24'd0, 24'd64, 1'b0}},
      '{'{ACT_SPARE,  8'd0,   16'sd0,     24'd0, 24'd0}, 1'b1, '{24'd0, 24'd64, 1'b0}},
      '{'{ACT_UPDATE, 8'd0,   16'sh7FFF,  24'd0, 24'd0}, 1'b1,
        '{24'h7FFF00, 24'h1FFFC0, 1'b0}},
      '{'{ACT_UPDATE, 8'd1,   16'sh8000,  24'd0, 24'd0}, 1'b1, '{24'd0, 24'd64, 1'b0}},
      '{'{ACT_UPDATE, 8'd2,   -16'sd1,    24'd0, 24'd0}, 1'b1, '{24'd0, 24'd64, 1'b0}},
      '{'{ACT_UPDATE, 8'd3,   16'sd0,     24'd0, 24'd0}, 1'b1, '{24'd0, 24'd64, 1'b0}},
      '{'{ACT_UPDATE, 8'd4,   16'sd1,     24'd0, 24'd0}, 1'b1, '{24'd256, 24'd64, 1'b0}},
      '{'{ACT_UPDATE, 8'd5,   16'sd2,     24'd0, 24'd0}, 1'b1, '{24'd512, 24'd128, 1'b0}},
      '{'{ACT_READ,   8'd0,   16'sd0,     24'd0, 24'd0}, 1'b1,
        '{24'h7FFF00, 24'h1FFFC0, 1'b1}},
      '{'{ACT_UPDATE, 8'd0,   16'sd0,     24'd0, 24'd0}, 1'b0, '0},
      '{'{ACT_UPDATE, 8'd0,   16'sh7FFF,  24'd0, 24'd0}, 1'b0, '0},
      '{'{ACT_UPDATE, 8'd1,   -16'sd5,    24'd0, 24'd0}, 1'b0, '0},
      '{'{ACT_SET,    8'd255, 16'sd0,  24'hFFFFFF, 24'hFFFFFF}, 1'b1,
        '{24'hFFFFFF, 24'hFFFFFF, 1'b0}},
      '{'{ACT_UPDATE, 8'd255, 16'sh7FFF,  24'd0, 24'd0}, 1'b0, '0},
      '{'{ACT_UPDATE, 8'd255, 16'sd0,     24'd0, 24'd0}, 1'b0, '0},
      '{'{ACT_SET,    8'd6,   16'sd0,     24'd0, 24'd0}, 1'b1, '{24'd0, 24'd64, 1'b0}},
      '{'{ACT_SET,    8'd6,   16'sd0,  24'h123456, 24'h10}, 1'b1,
        '{24'h123456, 24'd64, 1'b1}},
      '{'{ACT_UPDATE, 8'd6,   16'sd100,   24'd0, 24'd0}, 1'b0, '0},
      '{'{ACT_READ,   8'd6,   16'sd0,     24'd0, 24'd0}, 1'b0, '0},
      '{'{ACT_SET,    8'd7,   16'sd0,  24'h5A5A5A, 24'hA5A5A5}, 1'b1,
        '{24'h5A5A5A, 24'hA5A5A5, 1'b0}},
      '{'{ACT_UPDATE, 8'd7,   16'sh5555,  24'd0, 24'd0}, 1'b0, '0},
      '{'{ACT_SPARE,  8'd7,   16'sh2AAA, 24'hFFFFFF, 24'hFFFFFF}, 1'b0, '0},
      '{'{ACT_READ,   8'd255, 16'sd0,     24'd0, 24'd0}, 1'b0, '0},
      '{'{ACT_UPDATE, 8'd128, 16'sh2AAA,  24'd0, 24'd0}, 1'b1,
        '{24'h2AAA00, 24'hAAA80, 1'b0}},
      '{'{ACT_UPDATE, 8'd4,   16'sh7FFF,  24'd0, 24'd0}, 1'b0, '0}
   };

   function automatic logic [63:0] raise_to_floor(input logic [63:0] v);
      return (v < {40'd0, floor_w}) ? {40'd0, floor_w} : v;
   endfunction

   // works out the result of one item and folds it into the shadow table
   function automatic demand_result_type predict_demand(input demand_item_type it);
      demand_result_type r;
      logic [63:0] m, sd, a, om, big_s, d, t, vp, var_q, nm, root, cand;
      r.known = est_valid[it.index];
      m = 64'd0;
      sd = {40'd0, floor_w};
      if (r.known) begin
         m = {40'd0, est_mean[it.index]};
         sd = {40'd0, est_sd[it.index]};
      end
      if (it.action == ACT_UPDATE) begin
         // negative sales count as nothing sold
         big_s = it.sale[SALE_W-1] ? 64'd0 : ({48'd0, it.sale} << FRAC_W);
         if (!r.known) begin
            m = big_s;
            sd = raise_to_floor(big_s >> 2);
         end else begin
            a = {48'd0, alpha_w};
            om = 64'd65536 - a;
            d = (big_s >= m) ? big_s - m : m - big_s;
            t = (a * d * d + 64'd32768) >> RND_SH;
            vp = sd * sd + t;
            var_q = om * (vp >> RND_SH) + ((om * {48'd0, vp[15:0]} + 64'd32768) >> RND_SH);
            nm = (a * big_s + om * m + 64'd32768) >> RND_SH;
            root = 64'd0;
            for (int b = ROOT_W - 1; b >= 0; b--) begin
               cand = root | (64'd1 << b);
               if (cand * cand <= var_q) root = cand;
            end
            m = (nm > Q_MAX) ? Q_MAX : nm;
            sd = raise_to_floor((root > Q_MAX) ? Q_MAX : root);
         end
      end else if (it.action == ACT_SET) begin
         m = {40'd0, it.set_mean};
         sd = raise_to_floor({40'd0, it.set_sd});
      end
      if (it.action == ACT_UPDATE || it.action == ACT_SET) begin
         est_valid[it.index] = 1'b1;
         est_mean[it.index] = m[Q_W-1:0];
         est_sd[it.index] = sd[Q_W-1:0];
      end
      r.mean = m[Q_W-1:0];
      r.sd = sd[Q_W-1:0];
      return r;
   endfunction

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // offers one item, in bursts with random gaps, and returns once it is taken
   task automatic offer_item(input demand_item_type it);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 10);
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 30) : $urandom_range(0, 6);
         if (gap != 0) begin
            @(negedge clock);
            req_chan.valid = 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_chan.action        = it.action;
      req_chan.product_index = it.index;
      req_chan.sold_qty      = it.sale;
      req_chan.set_mean      = it.set_mean;
      req_chan.set_std_dev   = it.set_sd;
      req_chan.valid         = 1'b1;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_chan.valid = 1'b0;
      while (expected_demand.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_ADDR_W-1:0] addr, input logic [31:0] data);
      logic [31:0] kept;
      kept = (addr == ALPHA_ADDR) ? (data & 32'h0000_FFFF) : (data & 32'h00FF_FFFF);
      @(negedge clock);
      psel = 1'b1;
      penable = 1'b0;
      pwrite = 1'b1;
      paddr = addr;
      pwdata = data;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      // read back straight after
      @(negedge clock);
      penable = 1'b0;
      pwrite = 1'b0;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== kept) begin
         $error("prdata: expected %0h, got %0h", kept, prdata);
         fault_count++;
      end
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      if (addr == ALPHA_ADDR) alpha_w = kept[ALPHA_W-1:0];
      else floor_w = kept[Q_W-1:0];
   endtask

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         results_seen++;
         if (expected_demand.size() == 0) begin
            $error("result with no item outstanding: mean %0h sd %0h known %0b",
                   rsp_chan.mean_out, rsp_chan.std_dev_out, rsp_chan.was_known);
            fault_count++;
         end else begin
            arrived = expected_demand[0];
            expected_demand.delete(0);
            if (rsp_chan.mean_out !== arrived.mean) begin
               $error("mean_out: expected %0h, got %0h", arrived.mean, rsp_chan.mean_out);
               fault_count++;
            end
            if (rsp_chan.std_dev_out !== arrived.sd) begin
               $error("std_dev_out: expected %0h, got %0h", arrived.sd, rsp_chan.std_dev_out);
               fault_count++;
            end
            if (rsp_chan.was_known !== arrived.known) begin
               $error("was_known: expected %0b, got %0b", arrived.known, rsp_chan.was_known);
               fault_count++;
            end
         end
      end
   end

   // result side stalls, plus one long hold so the block backs up
   initial begin : result_sink
      int stall_pct;
      int cyc;
      bit held;
      rsp_chan.ready = 1'b0;
      stall_pct = 0;
      cyc = 0;
      held = 1'b0;
      forever begin
         @(negedge clock);
         if (!held && results_seen >= HOLD_AFTER) begin
            held = 1'b1;
            rsp_chan.ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         if (cyc % 100 == 0) begin
            case ($urandom_range(0, 3))
               0: stall_pct = 0;
               1: stall_pct = 20;
               2: stall_pct = 50;
               default: stall_pct = 85;
            endcase
         end
         cyc++;
         rsp_chan.ready = ($urandom_range(0, 99) >= stall_pct);
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin : stimulus
      demand_item_type it;
      demand_result_type r;
      int pick;
      req_chan.valid = 1'b0;
      req_chan.action = ACT_READ;
      req_chan.product_index = '0;
      req_chan.sold_qty = '0;
      req_chan.set_mean = '0;
      req_chan.set_std_dev = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      reset = 1'b1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (dir_tab[i]) begin
         offer_item(dir_tab[i].item);
         r = predict_demand(dir_tab[i].item);
         expected_demand.insert(expected_demand.size(), dir_tab[i].typed ? dir_tab[i].want : r);
      end
      drain_results();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            1: begin
               write_csr(ALPHA_ADDR, ($urandom & 32'hFFFF_0000) | 32'd1);
               write_csr(FLOOR_ADDR, ($urandom & 32'hFF00_0000) | 32'd0);
            end
            2: begin
               write_csr(ALPHA_ADDR, ($urandom & 32'hFFFF_0000) | 32'd65535);
               write_csr(FLOOR_ADDR, ($urandom & 32'hFF00_0000) | 32'hFF_FFFF);
            end
            3: begin
               // alpha of zero: full weight on the old mean
               write_csr(ALPHA_ADDR, 32'd0);
               write_csr(FLOOR_ADDR, 32'd64);
            end
            4: begin
               write_csr(ALPHA_ADDR, $urandom_range(1, 65535));
               write_csr(FLOOR_ADDR, $urandom_range(0, 4096));
            end
            5: begin
               write_csr(ALPHA_ADDR, 32'd16384);
               write_csr(FLOOR_ADDR, 32'd256);
            end
            default: ;
         endcase
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            pick = $urandom_range(0, 19);
            if (pick < 11) it.action = ACT_UPDATE;
            else if (pick < 15) it.action = ACT_READ;
            else if (pick < 18) it.action = ACT_SET;
            else it.action = ACT_SPARE;
            // mostly a small set of products so entries see repeated updates
            it.index = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 15)) : 8'($urandom);
            case ($urandom_range(0, 9))
               0: it.sale = 16'sh7FFF;
               1: it.sale = 16'($urandom) | 16'h8000;
               2: it.sale = 16'sd0;
               3, 4, 5, 6: it.sale = 16'($urandom_range(0, 300));
               default: it.sale = 16'($urandom);
            endcase
            it.set_mean = $urandom_range(0, 1) ? 24'($urandom) : 24'($urandom_range(0, 65535));
            it.set_sd = $urandom_range(0, 1) ? 24'($urandom) : 24'($urandom_range(0, 4096));
            offer_item(it);
            expected_demand.insert(expected_demand.size(), predict_demand(it));
         end
         drain_results();
      end

      repeat (60) @(posedge clock);
      if (fault_count == 0 && expected_demand.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
